[rtl/gbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_pkg: shared types and constants for the graph traversal block
// Vertex and count widths, operation and status codes.
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = $clog2(MaxVertices + 1);
  localparam int unsigned AddrW       = 2 * VtxW;

  typedef logic [VtxW-1:0] vtx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpBfs = 2'd1,
    OpDfs = 2'd2,
    OpBad = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StAdded   = 2'd0,
    StPresent = 2'd1,
    StReject  = 2'd2,
    StVisit   = 2'd3
  } status_e;

endpackage

[rtl/gbt_nbr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_nbr_ram: neighbor list store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbt_nbr_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [gbt_pkg::AddrW-1:0] waddr_i,
  input  gbt_pkg::vtx_t             wdata_i,
  input  logic [gbt_pkg::AddrW-1:0] raddr_i,
  output gbt_pkg::vtx_t             rdata_o
);
  import gbt_pkg::*;

  vtx_t mem_q [MaxVertices*MaxVertices];
  vtx_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/graph_bfs_dfs_traversal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal: directed graph store with BFS and DFS walks
// Add-edge with duplicate check; walks emit visited vertices in order.
//
// channel | direction | signals
// in      | input     | in_valid_i, in_stall_o, operation_i, src_i, dst_i
// out     | output    | out_valid_o, out_stall_i, status_o, vertex_o, is_last_o
// cfg     | input     | cfg_we_i, cfg_wdata_i
//
// One word is processed at a time; in_stall_o is high until its last
// result has been taken. Every neighbor-store read is issued, then its
// data is registered before use. A walk collects its visits first, then
// streams them out. Reset clears neighbor counts, marks and control and
// sets the vertex count to 16; the neighbor store is not cleared.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [4:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             operation_i,
  input  gbt_pkg::vtx_t          src_i,
  input  gbt_pkg::vtx_t          dst_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output gbt_pkg::vtx_t          vertex_o,
  output logic                   is_last_o
);
  import gbt_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SStart, SSingle, SAddChk, SAddCmp, SBfsPop, SBfsChk, SBfsNb,
    SDfsTop, SDfsNb, SOut
  } state_e;

  state_e                 state_q;
  logic [4:0]             vcnt_q;
  op_e                    op_q;
  vtx_t                   a_q, b_q;
  cnt_t                   ncount_q [MaxVertices];
  logic [MaxVertices-1:0] visited_q;
  vtx_t                   queue_q [MaxVertices];
  vtx_t                   stk_v_q [MaxVertices];
  cnt_t                   stk_i_q [MaxVertices];
  vtx_t                   res_q [MaxVertices];
  cnt_t                   head_q, tail_q, top_q, idx_q, rcnt_q, optr_q;
  vtx_t                   cur_q;
  logic                   ov_q, last_q;
  status_e                status_q;
  vtx_t                   vertex_q;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  vtx_t                   ram_rdata;

  cnt_t          act;
  logic          act_ok_a, act_ok_b;
  cnt_t          top_m1;
  vtx_t          top_v;
  cnt_t          top_i;

  always_comb begin
    act = (vcnt_q > cnt_t'(MaxVertices)) ? cnt_t'(MaxVertices) : vcnt_q;
    act_ok_a = cnt_t'(a_q) < act;
    act_ok_b = cnt_t'(b_q) < act;
    top_m1 = top_q - cnt_t'(1);
    top_v = stk_v_q[top_m1[VtxW-1:0]];
    top_i = stk_i_q[top_m1[VtxW-1:0]];
  end

  assign ram_we    = (state_q == SAddChk) && (idx_q >= ncount_q[a_q])
                     && (idx_q < cnt_t'(MaxVertices));
  assign ram_waddr = {a_q, idx_q[VtxW-1:0]};
  // DFS reads the next neighbor of the stack top straight away
  assign ram_raddr = (state_q == SDfsTop) ? {top_v, top_i[VtxW-1:0]}
                                          : {cur_q, idx_q[VtxW-1:0]};

  gbt_nbr_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (b_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      vcnt_q    <= 5'd16;
      op_q      <= OpAdd;
      a_q       <= '0;
      b_q       <= '0;
      cur_q     <= '0;
      visited_q <= '0;
      head_q <= '0; tail_q <= '0; top_q <= '0; idx_q <= '0;
      rcnt_q <= '0; optr_q <= '0;
      ov_q <= 1'b0; last_q <= 1'b0; status_q <= StAdded; vertex_q <= '0;
      for (int i = 0; i < MaxVertices; i++) begin
        ncount_q[i] <= '0;
        queue_q[i]  <= '0;
        stk_v_q[i]  <= '0;
        stk_i_q[i]  <= '0;
        res_q[i]    <= '0;
      end
    end else begin
      if (cfg_we_i) vcnt_q <= cfg_wdata_i;
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            op_q    <= op_e'(operation_i);
            a_q     <= src_i;
            b_q     <= dst_i;
            state_q <= SStart;
          end
        end
        SStart: begin
          case (op_q)
            OpAdd: begin
              if (act_ok_a && act_ok_b) begin
                cur_q <= a_q; idx_q <= '0; state_q <= SAddChk;
              end else begin
                ov_q <= 1'b1; status_q <= StReject; vertex_q <= '0; last_q <= 1'b1;
                state_q <= SSingle;
              end
            end
            OpBfs: begin
              if (act != '0) begin
                visited_q <= MaxVertices'(1);
                queue_q[0] <= '0;
                head_q <= '0; tail_q <= cnt_t'(1); rcnt_q <= '0;
                state_q <= SBfsPop;
              end else begin
                ov_q <= 1'b1; status_q <= StReject; vertex_q <= '0; last_q <= 1'b1;
                state_q <= SSingle;
              end
            end
            OpDfs: begin
              if (act_ok_a) begin
                visited_q <= MaxVertices'(1) << a_q;
                stk_v_q[0] <= a_q; stk_i_q[0] <= '0;
                top_q <= cnt_t'(1);
                res_q[0] <= a_q; rcnt_q <= cnt_t'(1);
                state_q <= SDfsTop;
              end else begin
                ov_q <= 1'b1; status_q <= StReject; vertex_q <= '0; last_q <= 1'b1;
                state_q <= SSingle;
              end
            end
            default: begin
              ov_q <= 1'b1; status_q <= StReject; vertex_q <= '0; last_q <= 1'b1;
              state_q <= SSingle;
            end
          endcase
        end
        SSingle: begin
          if (!out_stall_i) begin
            ov_q <= 1'b0; state_q <= SIdle;
          end
        end
        SAddChk: begin
          if (idx_q >= ncount_q[a_q]) begin
            ov_q <= 1'b1; vertex_q <= '0; last_q <= 1'b1; state_q <= SSingle;
            if (idx_q < cnt_t'(MaxVertices)) begin
              status_q <= StAdded;
              ncount_q[a_q] <= idx_q + cnt_t'(1);
            end else begin
              // full list counts as already present
              status_q <= StPresent;
            end
          end else begin
            state_q <= SAddCmp;
          end
        end
        SAddCmp: begin
          if (ram_rdata == b_q) begin
            ov_q <= 1'b1; status_q <= StPresent; vertex_q <= '0; last_q <= 1'b1;
            state_q <= SSingle;
          end else begin
            idx_q <= idx_q + cnt_t'(1); state_q <= SAddChk;
          end
        end
        SBfsPop: begin
          if (head_q < tail_q) begin
            cur_q <= queue_q[head_q[VtxW-1:0]];
            res_q[rcnt_q[VtxW-1:0]] <= queue_q[head_q[VtxW-1:0]];
            rcnt_q <= rcnt_q + cnt_t'(1);
            head_q <= head_q + cnt_t'(1);
            idx_q <= '0;
            state_q <= SBfsChk;
          end else begin
            optr_q <= '0; state_q <= SOut;
          end
        end
        SBfsChk: begin
          if (idx_q < ncount_q[cur_q]) state_q <= SBfsNb;
          else state_q <= SBfsPop;
        end
        SBfsNb: begin
          if (!visited_q[ram_rdata] && tail_q < cnt_t'(MaxVertices)) begin
            visited_q[ram_rdata] <= 1'b1;
            queue_q[tail_q[VtxW-1:0]] <= ram_rdata;
            tail_q <= tail_q + cnt_t'(1);
          end
          idx_q <= idx_q + cnt_t'(1);
          state_q <= SBfsChk;
        end
        SDfsTop: begin
          if (top_q == '0) begin
            optr_q <= '0; state_q <= SOut;
          end else if (top_i < ncount_q[top_v]) begin
            stk_i_q[top_m1[VtxW-1:0]] <= top_i + cnt_t'(1);
            state_q <= SDfsNb;
          end else begin
            top_q <= top_m1;
          end
        end
        SDfsNb: begin
          if (!visited_q[ram_rdata] && top_q < cnt_t'(MaxVertices)) begin
            visited_q[ram_rdata] <= 1'b1;
            res_q[rcnt_q[VtxW-1:0]] <= ram_rdata;
            rcnt_q <= rcnt_q + cnt_t'(1);
            stk_v_q[top_q[VtxW-1:0]] <= ram_rdata;
            stk_i_q[top_q[VtxW-1:0]] <= '0;
            top_q <= top_q + cnt_t'(1);
          end
          state_q <= SDfsTop;
        end
        SOut: begin
          if (!ov_q || !out_stall_i) begin
            if (optr_q < rcnt_q) begin
              ov_q <= 1'b1;
              status_q <= StVisit;
              vertex_q <= res_q[optr_q[VtxW-1:0]];
              last_q <= (optr_q + cnt_t'(1)) == rcnt_q;
              optr_q <= optr_q + cnt_t'(1);
            end else begin
              ov_q <= 1'b0; state_q <= SIdle;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = ov_q;
  assign status_o    = status_q;
  assign vertex_o    = vertex_q;
  assign is_last_o   = last_q;

endmodule
